// ===== rtl/b2b_pkg.sv =====
// Package for the BLAKE2b engine: payload structs, IV, sigma table, helpers.
// No dependencies.
`timescale 1ns / 1ps
package b2b_pkg;
	localparam int ROUNDS_DEF = 12;
	localparam logic [31:0] PARAM_WORD = 32'h0101_0000;

	// configuration register indexes
	localparam logic [0:0] REG_DIGEST_BYTES = 1'b0;
	localparam logic [0:0] REG_KEY_BYTES    = 1'b1;

	typedef struct packed {
		logic [63:0] data_word;
		logic [3:0]  byte_count;
		logic        end_of_key;
		logic        end_of_message;
	} in_beat_t;

	typedef struct packed {
		logic [63:0] digest_word;
		logic [2:0]  digest_word_index;
		logic [3:0]  valid_bytes;
		logic        last_word;
	} out_beat_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_ABSORB, ST_TAIL, ST_LOAD, ST_ROUND, ST_FINISH, ST_EMIT
	} st_t;

	localparam logic [0:7][63:0] IV = {
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
		64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
		64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
		64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179
	};

	localparam logic [0:9][0:15][3:0] SIGMA = {
		{4'd0,4'd1,4'd2,4'd3,4'd4,4'd5,4'd6,4'd7,4'd8,4'd9,4'd10,4'd11,4'd12,4'd13,4'd14,4'd15},
		{4'd14,4'd10,4'd4,4'd8,4'd9,4'd15,4'd13,4'd6,4'd1,4'd12,4'd0,4'd2,4'd11,4'd7,4'd5,4'd3},
		{4'd11,4'd8,4'd12,4'd0,4'd5,4'd2,4'd15,4'd13,4'd10,4'd14,4'd3,4'd6,4'd7,4'd1,4'd9,4'd4},
		{4'd7,4'd9,4'd3,4'd1,4'd13,4'd12,4'd11,4'd14,4'd2,4'd6,4'd5,4'd10,4'd4,4'd0,4'd15,4'd8},
		{4'd9,4'd0,4'd5,4'd7,4'd2,4'd4,4'd10,4'd15,4'd14,4'd1,4'd11,4'd12,4'd6,4'd8,4'd3,4'd13},
		{4'd2,4'd12,4'd6,4'd10,4'd0,4'd11,4'd8,4'd3,4'd4,4'd13,4'd7,4'd5,4'd15,4'd14,4'd1,4'd9},
		{4'd12,4'd5,4'd1,4'd15,4'd14,4'd13,4'd4,4'd10,4'd0,4'd7,4'd6,4'd3,4'd9,4'd2,4'd8,4'd11},
		{4'd13,4'd11,4'd7,4'd14,4'd12,4'd1,4'd3,4'd9,4'd5,4'd0,4'd15,4'd4,4'd8,4'd6,4'd2,4'd10},
		{4'd6,4'd15,4'd14,4'd9,4'd11,4'd3,4'd0,4'd8,4'd12,4'd13,4'd1,4'd10,4'd2,4'd4,4'd7,4'd5},
		{4'd10,4'd2,4'd8,4'd4,4'd7,4'd6,4'd1,4'd5,4'd15,4'd11,4'd9,4'd14,4'd3,4'd12,4'd13,4'd0}
	};

	function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
		rotr = (v >> n) | (v << (64 - n));
	endfunction

	// Digest length forced into 1..64.
	function automatic logic [6:0] clamp_digest(input logic [6:0] d);
		clamp_digest = (d == 7'd0) ? 7'd1 : ((d > 7'd64) ? 7'd64 : d);
	endfunction

	// Chain word 0 after parameter block fold-in, registers clamped.
	function automatic logic [63:0] h0_init(input logic [6:0] d, input logic [6:0] k);
		logic [6:0] dc;
		logic [6:0] kc;
		dc = clamp_digest(d);
		kc = (k > 7'd64) ? 7'd64 : k;
		h0_init = IV[0] ^ {32'd0, PARAM_WORD} ^ {49'd0, kc, 8'd0} ^ {57'd0, dc};
	endfunction
endpackage

// ===== rtl/b2b_msg_ram.sv =====
// Block store: 16 x 64-bit message memory, one write and one read port.
// Depends on nothing.
`timescale 1ns / 1ps
module b2b_msg_ram (
	input  logic        clk,
	input  logic        we,
	input  logic [3:0]  waddr,
	input  logic [63:0] wdata,
	input  logic [3:0]  raddr,
	output logic [63:0] rdata
);
	logic [63:0] mem [16];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== rtl/b2b_round.sv =====
// Half a G function per cycle while step is high, over a 16-word working vector held in registers.
// Depends on b2b_pkg.
`timescale 1ns / 1ps
module b2b_round (
	input  logic        clk,
	input  logic        load,
	input  logic [0:15][63:0] v_init,
	input  logic        step,
	input  logic        half,
	input  logic [2:0]  g_sel,
	input  logic [63:0] m,
	output logic [0:15][63:0] v_q
);
	import b2b_pkg::*;
	logic [3:0] ia, ib, ic, id;
	logic [63:0] a_n, b_n, c_n, d_n, x1, x2;
	logic [0:15][63:0] v_n;

	// index quadruple for the selected mix, then one half of it
	always_comb begin
		case (g_sel)
			3'd0: begin ia = 4'd0; ib = 4'd4; ic = 4'd8;  id = 4'd12; end
			3'd1: begin ia = 4'd1; ib = 4'd5; ic = 4'd9;  id = 4'd13; end
			3'd2: begin ia = 4'd2; ib = 4'd6; ic = 4'd10; id = 4'd14; end
			3'd3: begin ia = 4'd3; ib = 4'd7; ic = 4'd11; id = 4'd15; end
			3'd4: begin ia = 4'd0; ib = 4'd5; ic = 4'd10; id = 4'd15; end
			3'd5: begin ia = 4'd1; ib = 4'd6; ic = 4'd11; id = 4'd12; end
			3'd6: begin ia = 4'd2; ib = 4'd7; ic = 4'd8;  id = 4'd13; end
			default: begin ia = 4'd3; ib = 4'd4; ic = 4'd9; id = 4'd14; end
		endcase
		a_n = v_q[ia] + v_q[ib] + m;
		x1 = v_q[id] ^ a_n;
		d_n = half ? rotr(x1, 16) : rotr(x1, 32);
		c_n = v_q[ic] + d_n;
		x2 = v_q[ib] ^ c_n;
		b_n = half ? rotr(x2, 63) : rotr(x2, 24);
		v_n = v_q;
		v_n[ia] = a_n;
		v_n[ib] = b_n;
		v_n[ic] = c_n;
		v_n[id] = d_n;
	end

	always_ff @(posedge clk) begin
		if (load) begin
			v_q <= v_init;
		end else if (step) begin
			v_q <= v_n;
		end
	end
endmodule

// ===== rtl/blake2b_hash_engine.sv =====
// BLAKE2b engine top level: word packing, block store, compression sequencer.
// Depends on b2b_pkg, b2b_msg_ram, b2b_round.
// A word is accepted in ST_IDLE, packed in ST_ABSORB (split when it crosses a
// memory word, skipped when empty) and closed in ST_TAIL; input stalls meanwhile.
// A compression (load, half a mix a cycle, fold) runs when a byte meets a full
// block, or after the last word before the digest.
// The digest leaves as up to eight beats, one a cycle unless stalled.
// Reset restores default registers; written-word flags keep the store clean.
`timescale 1ns / 1ps
module blake2b_hash_engine #(
	parameter int ROUNDS = b2b_pkg::ROUNDS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  b2b_pkg::in_beat_t   in_data,
	output logic                out_valid,
	input  logic                out_stall,
	output b2b_pkg::out_beat_t  out_data,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_index,
	input  logic [6:0]          cfg_wdata
);
	import b2b_pkg::*;
	localparam int RW = $clog2(ROUNDS + 1);

	st_t         st_q, st_d;
	logic [6:0]  dig_cfg_q, key_cfg_q, run_dig_q;
	logic        run_q;
	logic        final_q;
	logic [0:7][63:0] h_q;
	logic [7:0]  fill_q;        // bytes in block, 128 means full
	logic [63:0] cur_q;         // partly filled memory word
	logic [127:0] tot_q;
	logic [15:0] mask_q;        // memory words written in this block
	logic [63:0] beat_q;        // bytes of the beat still to pack, low first
	logic [3:0]  rem_q;
	logic        eok_q, eom_q;
	logic [RW-1:0] rnd_q, rnd_n;
	logic [3:0]  smod_q, smod_n; // round number wrapped at ten
	logic [2:0]  g_q, g_n;
	logic        half_q, half_n;
	logic        rd_ok_s1;
	logic [3:0]  oidx_q;
	logic [3:0]  nwords;

	// memory ports
	logic        we;
	logic [3:0]  waddr, raddr;
	logic [63:0] wdata, rdata, mword;
	logic        v_load, v_step;
	logic [0:15][63:0] v_init, v_q;

	logic        in_go, out_go, out_last, last_step;
	logic [3:0]  cnt, space, take;
	logic [2:0]  pos;
	logic [63:0] merged;
	logic [7:0]  fill_eff;

	b2b_msg_ram u_ram (.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata));
	b2b_round u_rnd (.clk(clk), .load(v_load), .v_init(v_init), .step(v_step),
		.half(half_q), .g_sel(g_q), .m(mword), .v_q(v_q));

	assign cnt = (in_data.byte_count > 4'd8) ? 4'd8 : in_data.byte_count;
	assign in_stall = (st_q != ST_IDLE);
	assign in_go = in_valid && !in_stall;

	// bytes that fit into the current memory word
	assign space = 4'd8 - {1'b0, fill_q[2:0]};
	assign take = (rem_q < space) ? rem_q : space;

	always_comb begin
		merged = cur_q;
		pos = '0;
		for (int i = 0; i < 8; i++) begin
			if (4'(i) < take) begin
				pos = fill_q[2:0] + 3'(i);
				merged[{pos, 3'd0} +: 8] = beat_q[8*i +: 8];
			end
		end
	end

	// key end pads a non-empty block to full
	assign fill_eff = (eok_q && fill_q != 8'd0) ? 8'd128 : fill_q;

	// unwritten words of the block read as zero
	assign mword = rd_ok_s1 ? rdata : '0;

	assign nwords = 4'((run_dig_q + 7'd7) >> 3);
	assign last_step = (rnd_q == RW'(ROUNDS - 1)) && (g_q == 3'd7) && half_q;

	// next mix position, which also addresses its message word
	always_comb begin
		rnd_n = rnd_q;
		smod_n = smod_q;
		g_n = g_q;
		half_n = !half_q;
		if (half_q) begin
			g_n = g_q + 3'd1;
			if (g_q == 3'd7) begin
				rnd_n = rnd_q + RW'(1);
				smod_n = (smod_q == 4'd9) ? 4'd0 : smod_q + 4'd1;
			end
		end
	end

	always_comb begin
		for (int i = 0; i < 8; i++) begin
			v_init[i] = h_q[i];
			v_init[i + 8] = IV[i];
		end
		v_init[12] = IV[4] ^ tot_q[63:0];
		v_init[13] = IV[5] ^ tot_q[127:64];
		if (final_q) v_init[14] = ~IV[6];
	end

	// state machine
	always_comb begin
		st_d = st_q;
		we = 1'b0; waddr = fill_q[6:3]; wdata = merged; raddr = '0;
		v_load = 1'b0; v_step = 1'b0;
		case (st_q)
			ST_IDLE: begin
				if (in_go) st_d = (cnt == 4'd0) ? ST_TAIL : ST_ABSORB;
			end
			ST_ABSORB: begin
				if (fill_q == 8'd128) begin
					st_d = ST_LOAD;
				end else begin
					we = 1'b1;
					if (take == rem_q) st_d = ST_TAIL;
				end
			end
			ST_TAIL: st_d = eom_q ? ST_LOAD : ST_IDLE;
			ST_LOAD: begin
				v_load = 1'b1;
				raddr = SIGMA[0][0];
				st_d = ST_ROUND;
			end
			ST_ROUND: begin
				v_step = 1'b1;
				raddr = SIGMA[smod_n][{g_n, half_n}];
				if (last_step) st_d = ST_FINISH;
			end
			ST_FINISH: st_d = final_q ? ST_EMIT : ST_ABSORB;
			ST_EMIT: if (out_go && out_last) st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	assign out_valid = (st_q == ST_EMIT);
	assign out_go = out_valid && !out_stall;
	assign out_last = (oidx_q + 4'd1 == nwords);

	always_comb begin
		logic [6:0] left;
		logic [3:0] vb;
		left = run_dig_q - {1'b0, oidx_q[2:0], 3'd0};
		vb = (left > 7'd8) ? 4'd8 : left[3:0];
		out_data.digest_word = (vb == 4'd8) ? h_q[oidx_q[2:0]] :
			h_q[oidx_q[2:0]] & ((64'd1 << {vb[2:0], 3'd0}) - 64'd1);
		out_data.digest_word_index = oidx_q[2:0];
		out_data.valid_bytes = vb;
		out_data.last_word = out_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE; dig_cfg_q <= 7'd64; key_cfg_q <= '0; run_q <= 1'b0;
			run_dig_q <= 7'd64; fill_q <= '0; cur_q <= '0; tot_q <= '0; mask_q <= '0;
			final_q <= 1'b0; beat_q <= '0; rem_q <= '0; eok_q <= 1'b0; eom_q <= 1'b0;
			rnd_q <= '0; smod_q <= '0; g_q <= '0; half_q <= 1'b0; rd_ok_s1 <= 1'b0;
			oidx_q <= '0;
			h_q[0] <= h0_init(7'd64, 7'd0);
			for (int i = 1; i < 8; i++) h_q[i] <= IV[i];
		end else begin
			st_q <= st_d;
			rd_ok_s1 <= mask_q[raddr];
			if (cfg_we) begin
				if (cfg_index == REG_DIGEST_BYTES) dig_cfg_q <= cfg_wdata;
				else key_cfg_q <= cfg_wdata;
			end
			// beat capture; the first beat of a run latches the registers
			if (in_go) begin
				beat_q <= in_data.data_word;
				rem_q <= cnt;
				eok_q <= in_data.end_of_key;
				eom_q <= in_data.end_of_message;
				if (!run_q) begin
					run_q <= 1'b1;
					run_dig_q <= clamp_digest(dig_cfg_q);
					h_q[0] <= h0_init(dig_cfg_q, key_cfg_q);
					for (int i = 1; i < 8; i++) h_q[i] <= IV[i];
					fill_q <= '0; cur_q <= '0; tot_q <= '0; mask_q <= '0;
				end
			end
			// packing, or counter update before a mid-stream compression
			if (st_q == ST_ABSORB) begin
				if (fill_q == 8'd128) begin
					tot_q <= tot_q + 128'd128;
					final_q <= 1'b0;
				end else begin
					mask_q[fill_q[6:3]] <= 1'b1;
					fill_q <= fill_q + {4'd0, take};
					rem_q <= rem_q - take;
					beat_q <= beat_q >> {take, 3'd0};
					cur_q <= (({1'b0, fill_q[2:0]} + take) == 4'd8) ? '0 : merged;
				end
			end
			// key end padding and message end
			if (st_q == ST_TAIL) begin
				fill_q <= fill_eff;
				if (eom_q) begin
					tot_q <= tot_q + {120'd0, fill_eff};
					final_q <= 1'b1;
				end
			end
			// round sequencing
			if (st_q == ST_LOAD) begin
				rnd_q <= '0; smod_q <= '0; g_q <= '0; half_q <= 1'b0;
			end else if (st_q == ST_ROUND) begin
				rnd_q <= rnd_n; smod_q <= smod_n; g_q <= g_n; half_q <= half_n;
			end
			if (st_q == ST_FINISH) begin
				for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] ^ v_q[i] ^ v_q[i + 8];
				oidx_q <= '0;
				if (!final_q) begin
					fill_q <= '0; cur_q <= '0; mask_q <= '0;
				end
			end
			if (out_go) begin
				oidx_q <= oidx_q + 4'd1;
				if (out_last) begin
					run_q <= 1'b0; final_q <= 1'b0;
				end
			end
		end
	end
endmodule

// ===== tb/sv/blake2b_hash_engine_test.sv =====
// Self-checking testbench for blake2b_hash_engine: directed and random key/message
// streams against an in-bench BLAKE2b digest predictor. Depends on b2b_pkg and blake2b_hash_engine.
`timescale 1ns / 1ps
module blake2b_hash_engine_test;
	import b2b_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int SETTLE_CYCLES  = 320;

	localparam logic [63:0] CHAIN_IV [8] = '{
		64'h6A09E667F3BCC908, 64'hBB67AE8584CAA73B,
		64'h3C6EF372FE94F82B, 64'hA54FF53A5F1D36F1,
		64'h510E527FADE682D1, 64'h9B05688C2B3E6C1F,
		64'h1F83D9ABFB41BD6B, 64'h5BE0CD19137E2179};
	localparam int WORD_ORDER [10][16] = '{
		'{0,1,2,3,4,5,6,7,8,9,10,11,12,13,14,15},
		'{14,10,4,8,9,15,13,6,1,12,0,2,11,7,5,3},
		'{11,8,12,0,5,2,15,13,10,14,3,6,7,1,9,4},
		'{7,9,3,1,13,12,11,14,2,6,5,10,4,0,15,8},
		'{9,0,5,7,2,4,10,15,14,1,11,12,6,8,3,13},
		'{2,12,6,10,0,11,8,3,4,13,7,5,15,14,1,9},
		'{12,5,1,15,14,13,4,10,0,7,6,3,9,2,8,11},
		'{13,11,7,14,12,1,3,9,5,0,15,4,8,6,2,10},
		'{6,15,14,9,11,3,0,8,12,13,1,10,2,4,7,5},
		'{10,2,8,4,7,6,1,5,15,11,9,14,3,12,13,0}};

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	in_beat_t in_data;
	logic out_valid;
	logic out_stall;
	out_beat_t out_data;
	logic cfg_we;
	logic [0:0] cfg_index;
	logic [6:0] cfg_wdata;

	// predictor state
	logic [6:0] reg_digest;
	logic [6:0] reg_key;
	logic [63:0] chain [8];
	logic [63:0] blk [16];
	logic [63:0] work [16];
	int unsigned blk_fill;
	logic [127:0] byte_total;
	int unsigned run_len;

	in_beat_t word_queue [$];
	out_beat_t digest_queue [$];
	int errors;
	int words_sent;
	int burst_left;
	int gap_left;
	int idle_cycles;
	int stall_mode;
	int stall_phase;

	blake2b_hash_engine i_dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
		.out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// ---------------- predictor ----------------
	function automatic logic [63:0] ror64(input logic [63:0] v, input int n);
		return (v >> n) | (v << (64 - n));
	endfunction

	function automatic void g_mix(input int a, input int b, input int c, input int d,
			input logic [63:0] x, input logic [63:0] y);
		work[a] = work[a] + work[b] + x;
		work[d] = ror64(work[d] ^ work[a], 32);
		work[c] = work[c] + work[d];
		work[b] = ror64(work[b] ^ work[c], 24);
		work[a] = work[a] + work[b] + y;
		work[d] = ror64(work[d] ^ work[a], 16);
		work[c] = work[c] + work[d];
		work[b] = ror64(work[b] ^ work[c], 63);
	endfunction

	function automatic void compress_block(input bit last_block);
		int s;
		for (int i = 0; i < 8; i++) begin
			work[i] = chain[i];
			work[i + 8] = CHAIN_IV[i];
		end
		work[12] ^= byte_total[63:0];
		work[13] ^= byte_total[127:64];
		if (last_block)
			work[14] = ~work[14];
		for (int r = 0; r < ROUNDS_DEF; r++) begin
			s = r % 10;
			g_mix(0, 4, 8, 12, blk[WORD_ORDER[s][0]], blk[WORD_ORDER[s][1]]);
			g_mix(1, 5, 9, 13, blk[WORD_ORDER[s][2]], blk[WORD_ORDER[s][3]]);
			g_mix(2, 6, 10, 14, blk[WORD_ORDER[s][4]], blk[WORD_ORDER[s][5]]);
			g_mix(3, 7, 11, 15, blk[WORD_ORDER[s][6]], blk[WORD_ORDER[s][7]]);
			g_mix(0, 5, 10, 15, blk[WORD_ORDER[s][8]], blk[WORD_ORDER[s][9]]);
			g_mix(1, 6, 11, 12, blk[WORD_ORDER[s][10]], blk[WORD_ORDER[s][11]]);
			g_mix(2, 7, 8, 13, blk[WORD_ORDER[s][12]], blk[WORD_ORDER[s][13]]);
			g_mix(3, 4, 9, 14, blk[WORD_ORDER[s][14]], blk[WORD_ORDER[s][15]]);
		end
		for (int i = 0; i < 8; i++)
			chain[i] ^= work[i] ^ work[i + 8];
	endfunction

	// Fresh chain from the (clamped) registers.
	function automatic void begin_hash();
		int unsigned dl;
		int unsigned kl;
		dl = (reg_digest == 0) ? 1 : ((reg_digest > 64) ? 64 : reg_digest);
		kl = (reg_key > 64) ? 64 : reg_key;
		for (int i = 0; i < 8; i++) begin
			chain[i] = CHAIN_IV[i];
			blk[i] = '0;
			blk[i + 8] = '0;
		end
		chain[0] ^= 64'h0101_0000 ^ (64'(kl) << 8) ^ 64'(dl);
		blk_fill = 0;
		byte_total = '0;
		run_len = dl;
	endfunction

	function automatic void take_byte(input logic [7:0] b);
		if (blk_fill >= 128) begin
			byte_total += 128;
			compress_block(1'b0);
			for (int i = 0; i < 16; i++)
				blk[i] = '0;
			blk_fill = 0;
		end
		blk[blk_fill >> 3] |= 64'(b) << (8 * (blk_fill & 7));
		blk_fill++;
	endfunction

	// One accepted word; on end of message queue the digest beats.
	function automatic void absorb_word(input in_beat_t w);
		int unsigned n;
		int unsigned nw;
		int unsigned left;
		out_beat_t d;
		n = (w.byte_count > 8) ? 8 : w.byte_count;
		for (int i = 0; i < n; i++)
			take_byte(w.data_word[8 * i +: 8]);
		if (w.end_of_key && blk_fill > 0)
			blk_fill = 128;
		if (w.end_of_message) begin
			byte_total += blk_fill;
			compress_block(1'b1);
			nw = (run_len + 7) / 8;
			for (int i = 0; i < nw; i++) begin
				left = run_len - 8 * i;
				d.valid_bytes = (left > 8) ? 4'd8 : 4'(left);
				d.digest_word = chain[i];
				if (left < 8)
					d.digest_word &= (64'd1 << (8 * left)) - 1;
				d.digest_word_index = 3'(i);
				d.last_word = (i + 1 == nw);
				digest_queue.push_back(d);
			end
			begin_hash();
		end
	endfunction

	// ---------------- input driver ----------------
	// Bursts of random length, random gaps; at most one assignment to in_valid per edge.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall)
				absorb_word(in_data);
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left <= gap_left - 1;
					in_valid <= 1'b0;
				end else if (word_queue.size() > 0) begin
					in_data <= word_queue.pop_front();
					in_valid <= 1'b1;
					if (burst_left <= 1) begin
						burst_left <= $urandom_range(20, 1);
						gap_left <= ($urandom_range(3, 0) == 0) ? 0 : $urandom_range(6, 1);
					end else begin
						burst_left <= burst_left - 1;
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ---------------- output stall pattern ----------------
	always @(posedge clk) begin
		if (stall_phase == 0) begin
			stall_mode <= $urandom_range(2, 0);
			stall_phase <= $urandom_range(300, 40);
		end else begin
			stall_phase <= stall_phase - 1;
		end
		case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(9, 0) < 3);
			default: out_stall <= ($urandom_range(9, 0) < 8);
		endcase
	end

	// ---------------- digest checker ----------------
	always @(posedge clk) begin
		out_beat_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (digest_queue.size() == 0) begin
				$error("digest beat with nothing expected: %h", out_data);
				errors++;
			end else begin
				e = digest_queue.pop_front();
				if (out_data.digest_word !== e.digest_word) begin
					$error("digest_word exp %h got %h", e.digest_word, out_data.digest_word);
					errors++;
				end
				if (out_data.digest_word_index !== e.digest_word_index) begin
					$error("digest_word_index exp %0d got %0d", e.digest_word_index,
						out_data.digest_word_index);
					errors++;
				end
				if (out_data.valid_bytes !== e.valid_bytes) begin
					$error("valid_bytes exp %0d got %0d", e.valid_bytes, out_data.valid_bytes);
					errors++;
				end
				if (out_data.last_word !== e.last_word) begin
					$error("last_word exp %0d got %0d", e.last_word, out_data.last_word);
					errors++;
				end
			end
		end
	end

	// ---------------- watchdog ----------------
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > WATCHDOG_LIMIT) begin
			$display("end of test: mismatches");
			$finish;
		end
	end

	// ---------------- helpers ----------------
	task automatic send_word(input logic [63:0] w, input int cnt, input bit eok, input bit eom);
		in_beat_t b;
		b.data_word = w;
		b.byte_count = 4'(cnt);
		b.end_of_key = eok;
		b.end_of_message = eom;
		word_queue.push_back(b);
		words_sent++;
	endtask

	// Everything sent, accepted and answered.
	task automatic wait_quiet();
		while (word_queue.size() > 0 || in_valid || digest_queue.size() > 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Engine idle here, so the write takes effect at once.
	task automatic write_reg(input logic [0:0] idx, input logic [6:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_DIGEST_BYTES)
			reg_digest = val;
		else
			reg_key = val;
		begin_hash();
	endtask

	function automatic logic [63:0] rand_word();
		return {$urandom, $urandom};
	endfunction

	// Key words (if any) then a message of whole words and a partial tail.
	task automatic send_hash(input int key_len, input int msg_words, input int tail);
		int k;
		k = key_len;
		while (k > 0) begin
			send_word(rand_word(), (k > 8) ? 8 : k, k <= 8, 1'b0);
			k -= 8;
		end
		for (int i = 0; i < msg_words; i++)
			send_word(rand_word(), 8, 1'b0, 1'b0);
		send_word(rand_word(), tail, 1'b0, 1'b1);
	endtask

	// ---------------- tests ----------------
	task automatic test_empty_and_short();
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 0, 1'b0, 1'b1);
		send_word(64'hFFFF_FFFF_FFFF_FFFF, 8, 1'b0, 1'b1);
		send_word(64'h0000_0000_0063_6261, 3, 1'b0, 1'b1);
		wait_quiet();
	endtask

	task automatic test_block_boundary();
		send_hash(0, 15, 8);
		send_hash(0, 16, 1);
		wait_quiet();
	endtask

	task automatic test_odd_counts();
		// oversized counts, partial words mid-stream, key end on an empty block
		send_word(64'h0, 0, 1'b1, 1'b0);
		send_word(rand_word(), 15, 1'b0, 1'b0);
		send_word(rand_word(), 3, 1'b0, 1'b0);
		send_word(rand_word(), 9, 1'b0, 1'b1);
		wait_quiet();
	endtask

	task automatic test_keyed();
		write_reg(REG_KEY_BYTES, 7'd64);
		send_hash(64, 1, 5);
		// key and message end on the same word
		send_word(rand_word(), 8, 1'b0, 1'b0);
		send_word(rand_word(), 4, 1'b1, 1'b1);
		wait_quiet();
		write_reg(REG_KEY_BYTES, 7'd127);
		send_hash(64, 0, 2);
		wait_quiet();
	endtask

	task automatic test_digest_lengths();
		write_reg(REG_KEY_BYTES, 7'd0);
		write_reg(REG_DIGEST_BYTES, 7'd1);
		send_hash(0, 0, 8);
		wait_quiet();
		write_reg(REG_DIGEST_BYTES, 7'd0);
		send_hash(0, 0, 4);
		wait_quiet();
		write_reg(REG_DIGEST_BYTES, 7'd28);
		send_hash(0, 1, 6);
		wait_quiet();
		write_reg(REG_DIGEST_BYTES, 7'd127);
		send_hash(0, 0, 7);
		wait_quiet();
	endtask

	task automatic test_random_streams();
		int kl;
		int mw;
		while (words_sent < 125) begin
			if ($urandom_range(3, 0) == 0) begin
				wait_quiet();
				write_reg(REG_DIGEST_BYTES, 7'($urandom_range(127, 0)));
				write_reg(REG_KEY_BYTES, ($urandom_range(4, 0) == 0) ? 7'($urandom_range(127, 0))
					: 7'($urandom_range(64, 0)));
			end
			kl = (reg_key > 64) ? 64 : reg_key;
			mw = ($urandom_range(7, 0) == 0) ? $urandom_range(40, 15) : $urandom_range(6, 0);
			if ($urandom_range(9, 0) == 0) begin
				// broken stream: random counts and flags
				for (int i = 0; i < mw; i++)
					send_word(rand_word(), $urandom_range(15, 0), $urandom_range(3, 0) == 0, 1'b0);
				send_word(rand_word(), $urandom_range(15, 0), $urandom_range(1, 0) == 1, 1'b1);
			end else begin
				send_hash(kl, mw, $urandom_range(8, 0));
			end
		end
		wait_quiet();
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_data = '0;
		out_stall = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_DIGEST_BYTES;
		cfg_wdata = '0;
		errors = 0;
		words_sent = 0;
		burst_left = 0;
		gap_left = 0;
		idle_cycles = 0;
		stall_mode = 0;
		stall_phase = 0;
		reg_digest = 7'd64;
		reg_key = 7'd0;
		begin_hash();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_short();
		test_block_boundary();
		test_odd_counts();
		test_keyed();
		test_digest_lengths();
		test_random_streams();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0 && digest_queue.size() == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end
endmodule

// ===== blake2b_hash_engine.f =====
rtl/b2b_pkg.sv
rtl/b2b_msg_ram.sv
rtl/b2b_round.sv
rtl/blake2b_hash_engine.sv
tb/sv/blake2b_hash_engine_test.sv
